// ===== design/p2g_pkg.sv =====
// Package for the pixel-to-ground grid interpolator.
// Holds grid sizes, field widths, request/result types, command/status structs
// and the saturation helper. Depends on nothing.
`default_nettype none

package p2g_pkg;

  // Grid geometry
  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 16;
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int GRID_AW   = ROW_W + COL_W;
  localparam int SRCH_W    = (ROW_W > COL_W) ? ROW_W : COL_W;

  // Field widths
  localparam int PIX_W = 12;
  localparam int Q_W   = 32;
  localparam int FRAC  = 16;

  // Divider: 48-bit dividend magnitude, 33-bit divisor magnitude
  localparam int NUM_W      = 48;
  localparam int DEN_W      = 33;
  localparam int DCNT_W     = $clog2(NUM_W + 1);
  localparam int SHORT_BITS = 16;
  localparam int FRAC_W     = 17;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_PT = 2'd0,
    OP_LOAD_HL = 2'd1,
    OP_LOAD_VL = 2'd2,
    OP_CONVERT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIV_RIGHT = 2'd0,
    DIV_LEFT  = 2'd1,
    DIV_FX    = 2'd2,
    DIV_FY    = 2'd3
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_CMP,
    ST_COL_RD,
    ST_COL_CMP,
    ST_LN0,
    ST_LN1,
    ST_LN2,
    ST_CHK,
    ST_MUL_UP,
    ST_UP,
    ST_MUL_DN,
    ST_DN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SUM_CHK,
    ST_RES_OK,
    ST_RES_FAIL
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [3:0]         row;
    logic [3:0]         col;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic signed [Q_W-1:0] line_slope;
    logic signed [Q_W-1:0] line_intercept;
  } req_t;

  typedef struct packed {
    logic signed [Q_W-1:0] ground_x;
    logic signed [Q_W-1:0] ground_y;
    logic                  valid_res;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic               acc;
    logic [GRID_AW-1:0] grid_addr;
    logic [ROW_W-1:0]   hl_addr;
    logic [COL_W-1:0]   vl_addr;
    logic               cap_ln0;
    logic               cap_ln1;
    logic               mul_en;
    logic               mul_sel;
    logic               up_en;
    logic               dn_en;
    logic               div_start;
    logic               div_cap;
    div_sel_t           div_sel;
    logic               res_wr;
    logic               res_ok;
    logic [ROW_W-1:0]   iy;
    logic [COL_W-1:0]   ix;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic gy_gt;
    logic gx_gt;
    logic slope_zero;
    logic sum_zero;
    logic div_busy;
    logic res_free;
  } sts_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [Q_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/p2g_if.sv =====
// Request and result channel interfaces (valid/ready handshake).
// Depends on p2g_pkg for the payload types.
`default_nettype none

interface p2g_req_if;
  logic          valid;
  logic          ready;
  p2g_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface p2g_res_if;
  logic          valid;
  logic          ready;
  p2g_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/p2g_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Full run of NUM_W steps, or a short run of SHORT_BITS steps. Depends on p2g_pkg.
`default_nettype none

module p2g_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic                       short_run,
  input  wire logic [p2g_pkg::NUM_W-1:0]  num,
  input  wire logic [p2g_pkg::DEN_W-1:0]  den,
  output logic                            busy,
  output logic [p2g_pkg::NUM_W-1:0]       quot
);
  import p2g_pkg::*;

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  rem_next;
  logic [DEN_W-1:0]  dvs;
  logic [NUM_W-1:0]  q;
  logic [DCNT_W-1:0] cnt;
  logic [DEN_W:0]    trial;
  logic              qbit;

  // One trial subtraction
  always_comb begin
    trial = {rem, q[NUM_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = DEN_W'(trial - {1'b0, dvs});
      qbit     = 1'b1;
    end else begin
      rem_next = trial[DEN_W-1:0];
      qbit     = 1'b0;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= short_run ? DCNT_W'(SHORT_BITS) : DCNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient; a short run assumes num >> SHORT_BITS < den
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= den;
      if (short_run) begin
        rem <= DEN_W'(num >> SHORT_BITS);
        q   <= num << (NUM_W - SHORT_BITS);
      end else begin
        rem <= '0;
        q   <= num;
      end
    end else if (busy) begin
      rem <= rem_next;
      q   <= {q[NUM_W-2:0], qbit};
    end
  end

  assign quot = q;

endmodule

`default_nettype wire

// ===== design/p2g_dp.sv =====
// Datapath: grid and line memories, centre registers, crossing multiplier,
// divider and result register. Depends on p2g_pkg, p2g_if and p2g_div.
`default_nettype none

module p2g_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire p2g_pkg::cmd_t                 cmd,
  output p2g_pkg::sts_t                      sts,
  input  wire p2g_pkg::req_t                 req_in,
  input  wire logic                          wr_en,
  input  wire logic [p2g_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [p2g_pkg::Q_W-1:0]       wr_data,
  p2g_res_if.source                          result
);
  import p2g_pkg::*;

  // Storage
  logic [2*PIX_W-1:0] grid_mem [GRID_ROWS*GRID_COLS];
  logic [2*Q_W-1:0]   hl_mem   [GRID_ROWS];
  logic [2*Q_W-1:0]   vl_mem   [GRID_COLS];
  logic [2*PIX_W-1:0] grid_q;
  logic [2*Q_W-1:0]   hl_q;
  logic [2*Q_W-1:0]   vl_q;

  req_t r;
  logic signed [Q_W-1:0] cx, cy;
  logic signed [Q_W-1:0] hs0, hi0, hs1, hi1, vs0, vi0, vs1, vi1;
  logic signed [44:0]    prod;
  logic [Q_W-1:0]        up, down, right, left;
  logic [FRAC_W-1:0]     fx, fy;
  logic                  div_neg;

  logic signed [63:0] px_fix, py_fix;
  logic signed [63:0] diff_h, abs_h;
  logic signed [Q_W-1:0] cross_h, cross_v;
  logic signed [Q_W-1:0] vs_sel, vi_sel;
  logic signed [63:0] vt, vmag, vs64, vsmag, qv, diff_v, abs_v;
  logic [NUM_W-1:0]   d_num;
  logic [DEN_W-1:0]   d_den;
  logic               d_short;
  logic               d_busy;
  logic [NUM_W-1:0]   d_quot;
  logic [DEN_W-1:0]   sum_ud, sum_lr;
  logic signed [63:0] gx, gy;
  logic               ov;
  res_t               od;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      r <= req_in;
    end
  end

  // Centre registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0;
      cy <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CENTER_X: cx <= wr_data;
        REG_CENTER_Y: cy <= wr_data;
        default: ;
      endcase
    end
  end

  // Table loads and registered reads
  always_ff @(posedge clk) begin
    if (cmd.acc && req_in.operation == OP_LOAD_PT &&
        int'(req_in.row) < GRID_ROWS && int'(req_in.col) < GRID_COLS) begin
      grid_mem[{req_in.row[ROW_W-1:0], req_in.col[COL_W-1:0]}] <=
        {req_in.pixel_x, req_in.pixel_y};
    end
    grid_q <= grid_mem[cmd.grid_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && req_in.operation == OP_LOAD_HL && int'(req_in.row) < GRID_ROWS) begin
      hl_mem[req_in.row[ROW_W-1:0]] <= {req_in.line_slope, req_in.line_intercept};
    end
    hl_q <= hl_mem[cmd.hl_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && req_in.operation == OP_LOAD_VL && int'(req_in.col) < GRID_COLS) begin
      vl_mem[req_in.col[COL_W-1:0]] <= {req_in.line_slope, req_in.line_intercept};
    end
    vl_q <= vl_mem[cmd.vl_addr];
  end

  // Bounding line capture
  always_ff @(posedge clk) begin
    if (cmd.cap_ln0) begin
      {hs0, hi0} <= hl_q;
      {vs0, vi0} <= vl_q;
    end
    if (cmd.cap_ln1) begin
      {hs1, hi1} <= hl_q;
      {vs1, vi1} <= vl_q;
    end
  end

  assign px_fix = $signed({36'b0, r.pixel_x, 16'b0});
  assign py_fix = $signed({36'b0, r.pixel_y, 16'b0});

  // Horizontal crossing: slope * px, then add intercept and measure
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= (cmd.mul_sel ? hs1 : hs0) * $signed({1'b0, r.pixel_x});
    end
  end

  always_comb begin
    cross_h = sat32(64'(prod) + 64'(cmd.mul_sel ? hi1 : hi0));
    diff_h  = py_fix - 64'(cross_h);
    abs_h   = (diff_h < 0) ? -diff_h : diff_h;
  end

  always_ff @(posedge clk) begin
    if (cmd.up_en) begin
      up <= abs_h[Q_W-1:0];
    end
    if (cmd.dn_en) begin
      down <= abs_h[Q_W-1:0];
    end
  end

  // Divider operand selection
  always_comb begin
    vs_sel  = (cmd.div_sel == DIV_RIGHT) ? vs1 : vs0;
    vi_sel  = (cmd.div_sel == DIV_RIGHT) ? vi1 : vi0;
    vt      = py_fix - 64'(vi_sel);
    vmag    = (vt < 0) ? -vt : vt;
    vs64    = 64'(vs_sel);
    vsmag   = (vs64 < 0) ? -vs64 : vs64;
    sum_ud  = DEN_W'(up) + DEN_W'(down);
    sum_lr  = DEN_W'(left) + DEN_W'(right);
    unique case (cmd.div_sel)
      DIV_RIGHT, DIV_LEFT: begin
        d_num   = {vmag[31:0], 16'b0};
        d_den   = vsmag[DEN_W-1:0];
        d_short = 1'b0;
      end
      DIV_FX: begin
        d_num   = NUM_W'({down, 15'b0});
        d_den   = sum_ud;
        d_short = 1'b1;
      end
      DIV_FY: begin
        d_num   = NUM_W'({right, 15'b0});
        d_den   = sum_lr;
        d_short = 1'b1;
      end
      default: begin
        d_num   = '0;
        d_den   = '0;
        d_short = 1'b0;
      end
    endcase
  end

  p2g_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .short_run (d_short),
    .num       (d_num),
    .den       (d_den),
    .busy      (d_busy),
    .quot      (d_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg <= (vt < 0) ^ vs_sel[Q_W-1];
    end
  end

  // Vertical crossing from the signed quotient
  always_comb begin
    qv      = div_neg ? -$signed({16'b0, d_quot}) : $signed({16'b0, d_quot});
    cross_v = sat32(qv);
    diff_v  = px_fix - 64'(cross_v);
    abs_v   = (diff_v < 0) ? -diff_v : diff_v;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_cap) begin
      unique case (cmd.div_sel)
        DIV_RIGHT: right <= abs_v[Q_W-1:0];
        DIV_LEFT:  left  <= abs_v[Q_W-1:0];
        DIV_FX:    fx    <= d_quot[FRAC_W-1:0];
        DIV_FY:    fy    <= d_quot[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Final offsets from the centre
  always_comb begin
    gx = 64'(cx) - $signed({{(64-ROW_W-15){1'b0}}, cmd.iy, 15'b0}) +
         $signed({{(64-FRAC_W){1'b0}}, fx});
    gy = 64'(cy) - $signed({{(64-COL_W-15){1'b0}}, cmd.ix, 15'b0}) +
         $signed({{(64-FRAC_W){1'b0}}, fy});
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (cmd.res_wr) begin
      ov <= 1'b1;
    end else if (result.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      if (cmd.res_ok) begin
        od.ground_x  <= sat32(gx);
        od.ground_y  <= sat32(gy);
        od.valid_res <= 1'b1;
      end else begin
        od.ground_x  <= '0;
        od.ground_y  <= '0;
        od.valid_res <= 1'b0;
      end
    end
  end

  assign result.valid = ov;
  assign result.data  = od;

  // Status
  assign sts.gy_gt      = grid_q[PIX_W-1:0] > r.pixel_y;
  assign sts.gx_gt      = grid_q[2*PIX_W-1:PIX_W] > r.pixel_x;
  assign sts.slope_zero = (hs0 == 0) || (hs1 == 0) || (vs0 == 0) || (vs1 == 0);
  assign sts.sum_zero   = (sum_ud == '0) || (sum_lr == '0);
  assign sts.div_busy   = d_busy;
  assign sts.res_free   = !ov || result.ready;

endmodule

`default_nettype wire

// ===== design/p2g_ctrl.sv =====
// Controller: sequences the row and column search, line reads, crossings,
// divisions and result write. Depends on p2g_pkg.
`default_nettype none

module p2g_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire p2g_pkg::op_t  in_op,
  output logic               in_ready,
  input  wire p2g_pkg::sts_t sts,
  output p2g_pkg::cmd_t      cmd
);
  import p2g_pkg::*;

  state_t            state, state_next;
  logic [SRCH_W-1:0] cnt, cnt_next;
  logic [ROW_W-1:0]  iy, iy_next;
  logic [COL_W-1:0]  ix, ix_next;
  div_sel_t          sel, sel_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      iy    <= '0;
      ix    <= '0;
      sel   <= DIV_RIGHT;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      iy    <= iy_next;
      ix    <= ix_next;
      sel   <= sel_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    iy_next    = iy;
    ix_next    = ix;
    sel_next   = sel;
    cmd        = '0;
    cmd.iy     = iy;
    cmd.ix     = ix;
    cmd.div_sel = sel;
    in_ready   = (state == ST_IDLE);
    cmd.acc    = in_valid && in_ready;
    cmd.hl_addr = (state == ST_LN0) ? iy - 1'b1 : iy;
    cmd.vl_addr = (state == ST_LN0) ? ix - 1'b1 : ix;
    if (state == ST_ROW_RD || state == ST_ROW_CMP) begin
      cmd.grid_addr = {cnt[ROW_W-1:0], {COL_W{1'b0}}};
    end else begin
      cmd.grid_addr = {iy, cnt[COL_W-1:0]};
    end

    unique case (state)
      ST_IDLE: begin
        if (cmd.acc && in_op == OP_CONVERT) begin
          cnt_next   = '0;
          state_next = ST_ROW_RD;
        end
      end
      ST_ROW_RD: state_next = ST_ROW_CMP;
      ST_ROW_CMP: begin
        if (sts.gy_gt) begin
          if (cnt == '0) begin
            state_next = ST_RES_FAIL;
          end else begin
            iy_next    = cnt[ROW_W-1:0];
            cnt_next   = '0;
            state_next = ST_COL_RD;
          end
        end else if (cnt == SRCH_W'(GRID_ROWS - 1)) begin
          state_next = ST_RES_FAIL;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ST_ROW_RD;
        end
      end
      ST_COL_RD: state_next = ST_COL_CMP;
      ST_COL_CMP: begin
        if (sts.gx_gt) begin
          if (cnt == '0) begin
            state_next = ST_RES_FAIL;
          end else begin
            ix_next    = cnt[COL_W-1:0];
            state_next = ST_LN0;
          end
        end else if (cnt == SRCH_W'(GRID_COLS - 1)) begin
          state_next = ST_RES_FAIL;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ST_COL_RD;
        end
      end
      ST_LN0: state_next = ST_LN1;
      ST_LN1: begin
        cmd.cap_ln0 = 1'b1;
        state_next  = ST_LN2;
      end
      ST_LN2: begin
        cmd.cap_ln1 = 1'b1;
        state_next  = ST_CHK;
      end
      ST_CHK: state_next = sts.slope_zero ? ST_RES_FAIL : ST_MUL_UP;
      ST_MUL_UP: begin
        cmd.mul_en = 1'b1;
        state_next = ST_UP;
      end
      ST_UP: begin
        cmd.up_en  = 1'b1;
        state_next = ST_MUL_DN;
      end
      ST_MUL_DN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 1'b1;
        state_next  = ST_DN;
      end
      ST_DN: begin
        cmd.mul_sel = 1'b1;
        cmd.dn_en   = 1'b1;
        sel_next    = DIV_RIGHT;
        state_next  = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!sts.div_busy) begin
          cmd.div_cap = 1'b1;
          unique case (sel)
            DIV_RIGHT: begin
              sel_next   = DIV_LEFT;
              state_next = ST_DIV_GO;
            end
            DIV_LEFT:  state_next = ST_SUM_CHK;
            DIV_FX: begin
              sel_next   = DIV_FY;
              state_next = ST_DIV_GO;
            end
            DIV_FY:    state_next = ST_RES_OK;
            default:   state_next = ST_RES_FAIL;
          endcase
        end
      end
      ST_SUM_CHK: begin
        if (sts.sum_zero) begin
          state_next = ST_RES_FAIL;
        end else begin
          sel_next   = DIV_FX;
          state_next = ST_DIV_GO;
        end
      end
      ST_RES_OK: begin
        if (sts.res_free) begin
          cmd.res_wr = 1'b1;
          cmd.res_ok = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RES_FAIL: begin
        if (sts.res_free) begin
          cmd.res_wr = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/pixel_to_ground_grid_interp.sv =====
// Pixel-to-ground grid interpolator, top level.
// Loads are taken while idle and leave the block idle. A convert searches rows, then columns,
// reads the bounding lines, forms the crossings and, unless a check fails, makes four divider
// runs (two full, two short); the next request can be taken in the same cycle as the result goes valid.
// A result still held in the output register keeps the controller waiting until taken.
// Synchronous active-high reset clears control, centre registers and result valid;
// grid and line tables hold no reset value.
`default_nettype none

module pixel_to_ground_grid_interp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  p2g_req_if.sink                            request,
  p2g_res_if.source                          result,
  input  wire logic                          wr_en,
  input  wire logic [p2g_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [p2g_pkg::Q_W-1:0]       wr_data
);
  import p2g_pkg::*;

  cmd_t cmd;
  sts_t sts;

  p2g_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_op    (request.data.operation),
    .in_ready (request.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  p2g_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req_in   (request.data),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .result   (result)
  );

  // New requests only with the divider quiet
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    request.ready |-> !sts.div_busy)
    else $error("request taken while divider busy");

  // Divider never restarted mid-run
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // Result never overwrites an untaken one
  a_res_wr: assert property (@(posedge clk) disable iff (rst)
    cmd.res_wr |-> sts.res_free)
    else $error("result overwritten");

  // Failure results carry zero coordinates
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.data.valid_res) |->
      (result.data.ground_x == 0 && result.data.ground_y == 0))
    else $error("failure result not zero");

endmodule

`default_nettype wire

// ===== test/pixel_to_ground_grid_interp_tb.sv =====
// Testbench for the pixel-to-ground grid interpolator: loads a calibration grid,
// converts pixels, and checks every result against a predictor of its own.
// Depends on p2g_pkg, p2g_req_if / p2g_res_if and pixel_to_ground_grid_interp.
`timescale 1ns / 100ps

module pixel_to_ground_grid_interp_tb;
  import p2g_pkg::*;

  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 600;

  logic clk;
  logic rst;
  logic wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [Q_W-1:0] wr_data;

  p2g_req_if req_ch ();
  p2g_res_if res_ch ();

  pixel_to_ground_grid_interp u_dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch.sink),
    .result   (res_ch.source),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Predictor state
  logic [PIX_W-1:0] grid_x [GRID_ROWS][GRID_COLS];
  logic [PIX_W-1:0] grid_y [GRID_ROWS][GRID_COLS];
  longint hl_slope [GRID_ROWS];
  longint hl_icpt  [GRID_ROWS];
  longint vl_slope [GRID_COLS];
  longint vl_icpt  [GRID_COLS];
  longint centre_x;
  longint centre_y;

  res_t expected_ground [$];
  int   mismatches;
  int   hold_count;
  bit   no_idle;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_count > 0) hold_count <= hold_count - 1;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  // Expected ground position of one pixel
  function automatic res_t ground_of_pixel(input longint px, input longint py);
    res_t r;
    int iy, ix;
    longint up, down, left, right, fx, fy;
    r = '0;
    iy = -1;
    ix = -1;
    for (int i = 0; i < GRID_ROWS; i++) begin
      if (grid_y[i][0] > py) begin
        iy = i;
        break;
      end
    end
    if (iy <= 0) return r;
    for (int i = 0; i < GRID_COLS; i++) begin
      if (grid_x[iy][i] > px) begin
        ix = i;
        break;
      end
    end
    if (ix <= 0) return r;
    if (hl_slope[iy] == 0 || hl_slope[iy-1] == 0) return r;
    if (vl_slope[ix] == 0 || vl_slope[ix-1] == 0) return r;
    up    = mag(py * 65536 - clamp32(hl_slope[iy-1] * px + hl_icpt[iy-1]));
    down  = mag(py * 65536 - clamp32(hl_slope[iy] * px + hl_icpt[iy]));
    right = mag(px * 65536 - clamp32(((py * 65536 - vl_icpt[ix]) * 65536) / vl_slope[ix]));
    left  = mag(px * 65536 -
                clamp32(((py * 65536 - vl_icpt[ix-1]) * 65536) / vl_slope[ix-1]));
    if (up + down == 0 || left + right == 0) return r;
    fx = (down * 32768) / (up + down);
    fy = (right * 32768) / (left + right);
    r.ground_x  = Q_W'(clamp32(centre_x - longint'(iy) * 32768 + fx));
    r.ground_y  = Q_W'(clamp32(centre_y - longint'(ix) * 32768 + fy));
    r.valid_res = 1'b1;
    return r;
  endfunction

  // Apply an accepted request to the predictor
  task automatic apply_request(input req_t q);
    case (q.operation)
      OP_LOAD_PT: begin
        grid_x[q.row][q.col] = q.pixel_x;
        grid_y[q.row][q.col] = q.pixel_y;
      end
      OP_LOAD_HL: begin
        hl_slope[q.row] = longint'(q.line_slope);
        hl_icpt[q.row]  = longint'(q.line_intercept);
      end
      OP_LOAD_VL: begin
        vl_slope[q.col] = longint'(q.line_slope);
        vl_icpt[q.col]  = longint'(q.line_intercept);
      end
      OP_CONVERT: expected_ground.insert(expected_ground.size(),
                                         ground_of_pixel(q.pixel_x, q.pixel_y));
    endcase
  endtask

  // Send one request; valid stays high across back-to-back requests
  task automatic send_request(input req_t q);
    int gap;
    bit taken;
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= q;
    do begin
      @(negedge clk);
      taken = req_ch.ready;
      @(posedge clk);
    end while (!taken);
    apply_request(q);
  endtask

  task automatic idle_request();
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Request builders
  function automatic req_t make_req(input op_t op, input int r, input int c,
                                    input int px, input int py,
                                    input logic [31:0] s, input logic [31:0] b);
    req_t q;
    q.operation      = op;
    q.row            = r[3:0];
    q.col            = c[3:0];
    q.pixel_x        = px[11:0];
    q.pixel_y        = py[11:0];
    q.line_slope     = s;
    q.line_intercept = b;
    return q;
  endfunction

  // Regular grid point with a little jitter; noise fields random
  function automatic req_t point_req(input int r, input int c);
    return make_req(OP_LOAD_PT, r, c, c * 256 + 32 + $urandom_range(0, 31),
                    r * 256 + 32 + $urandom_range(0, 31), $urandom, $urandom);
  endfunction

  // Near-horizontal line close to row r
  function automatic req_t hline_req(input int r);
    int s;
    s = $urandom_range(1, 6553);
    if ($urandom_range(0, 1)) s = -s;
    return make_req(OP_LOAD_HL, r, $urandom_range(0, 15), $urandom, $urandom, s,
                    (r * 256 + 32 + $urandom_range(0, 31)) * 65536 - s * 2048);
  endfunction

  // Steep line close to column c
  function automatic req_t vline_req(input int c);
    longint s;
    s = longint'($urandom_range(4, 7)) * 65536 + $urandom_range(0, 65535);
    if ($urandom_range(0, 1)) s = -s;
    return make_req(OP_LOAD_VL, $urandom_range(0, 15), c, $urandom, $urandom, 32'(s),
                    32'(2048 * 65536 - s * (c * 256 + 32 + $urandom_range(0, 31))));
  endfunction

  function automatic req_t convert_req(input int px, input int py);
    return make_req(OP_CONVERT, $urandom, $urandom, px, py, $urandom, $urandom);
  endfunction

  // Wait for the block to go idle, then write a centre register
  task automatic write_centre(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    wait (expected_ground.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_CENTER_X) centre_x = longint'(signed'(val));
    else centre_y = longint'(signed'(val));
  endtask

  // Result checker with random stalls
  initial begin
    res_t got, want;
    int stall;
    bit seen;
    res_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0 || hold_count > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_count > 0) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        seen = res_ch.valid;
        got  = res_ch.data;
        @(posedge clk);
      end while (!seen);
      if (expected_ground.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result x=%0d y=%0d v=%0b",
                   got.ground_x, got.ground_y, got.valid_res);
      end else begin
        want = expected_ground.pop_front();
        if (got.ground_x !== want.ground_x || got.ground_y !== want.ground_y ||
            got.valid_res !== want.valid_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp x=%0d y=%0d v=%0b got x=%0d y=%0d v=%0b",
                     want.ground_x, want.ground_y, want.valid_res,
                     got.ground_x, got.ground_y, got.valid_res);
        end
      end
    end
  end

  // Tests
  task automatic test_load_grid();
    for (int r = 0; r < GRID_ROWS; r++) begin
      send_request(hline_req(r));
      for (int c = 0; c < GRID_COLS; c++) send_request(point_req(r, c));
    end
    for (int c = 0; c < GRID_COLS; c++) send_request(vline_req(c));
  endtask

  task automatic test_directed();
    // pixel-space corners above and below the grid, then a pixel inside it
    send_request(convert_req(0, 0));
    send_request(convert_req(4095, 4095));
    send_request(convert_req(4095, 0));
    send_request(convert_req(0, 4095));
    send_request(convert_req(1000, 1400));
    // grid point at field extremes, then put the point back
    send_request(make_req(OP_LOAD_PT, 15, 15, 4095, 4095, 0, 0));
    send_request(convert_req(4000, 3900));
    send_request(point_req(15, 15));
    // zero slope on a bounding vertical line
    send_request(make_req(OP_LOAD_VL, 0, 4, 0, 0, 32'd0, 32'd0));
    send_request(convert_req(1000, 1400));
    send_request(vline_req(4));
    // both horizontal lines through the pixel: zero denominator
    send_request(make_req(OP_LOAD_HL, 5, 0, 0, 0, 32'd1, 1400 * 65536 - 1000));
    send_request(make_req(OP_LOAD_HL, 6, 0, 0, 0, 32'd1, 1400 * 65536 - 1000));
    send_request(convert_req(1000, 1400));
    // saturating crossings from extreme slopes and intercepts
    send_request(make_req(OP_LOAD_HL, 5, 0, 0, 0, 32'h7fffffff, 32'h80000000));
    send_request(make_req(OP_LOAD_HL, 6, 0, 0, 0, 32'h80000000, 32'h7fffffff));
    send_request(make_req(OP_LOAD_VL, 0, 3, 0, 0, 32'h00000001, 32'h7fffffff));
    send_request(make_req(OP_LOAD_VL, 0, 4, 0, 0, 32'hffffffff, 32'h80000000));
    send_request(convert_req(1000, 1400));
    send_request(hline_req(5));
    send_request(hline_req(6));
    send_request(vline_req(3));
    send_request(vline_req(4));
    send_request(convert_req(1000, 1400));
  endtask

  // Mostly converts inside the grid, with reloads of random content
  task automatic test_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n % 97 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_request(convert_req($urandom_range(0, 4095), $urandom_range(0, 4095)));
      else if (pick < 80)
        send_request(point_req($urandom_range(0, 15), $urandom_range(0, 15)));
      else if (pick < 85)
        send_request(make_req(OP_LOAD_PT, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom));
      else if (pick < 91)
        send_request(hline_req($urandom_range(0, 15)));
      else if (pick < 97)
        send_request(vline_req($urandom_range(0, 15)));
      else if (pick < 98)
        send_request(make_req(OP_LOAD_HL, $urandom, $urandom, 0, 0, $urandom, $urandom));
      else
        send_request(make_req(OP_LOAD_VL, $urandom, $urandom, 0, 0, $urandom, $urandom));
    end
    no_idle = 1'b0;
  endtask

  // Receiver holds off while converts keep coming
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_count = HOLD_CYCLES;
    for (int n = 0; n < 12; n++)
      send_request(convert_req($urandom_range(200, 3900), $urandom_range(200, 3900)));
    no_idle = 1'b0;
  endtask

  // Sender pauses until every result is in
  task automatic test_drain_pause();
    for (int n = 0; n < 8; n++)
      send_request(convert_req($urandom_range(0, 4095), $urandom_range(0, 4095)));
    idle_request();
    wait (expected_ground.size() == 0);
    send_request(convert_req(2000, 2000));
  endtask

  // Main sequence
  initial begin
    mismatches = 0;
    hold_count = 0;
    no_idle = 1'b0;
    centre_x = 0;
    centre_y = 0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_CENTER_X;
    wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_load_grid();
    test_directed();
    test_random(300);
    idle_request();
    write_centre(REG_CENTER_X, 32'h7fffffff);
    write_centre(REG_CENTER_Y, 32'h80000000);
    test_random(250);
    test_backpressure();
    idle_request();
    write_centre(REG_CENTER_X, 32'h80000000);
    write_centre(REG_CENTER_Y, 32'h7fffffff);
    test_random(250);
    test_drain_pause();
    idle_request();
    write_centre(REG_CENTER_X, $urandom);
    write_centre(REG_CENTER_Y, $urandom);
    test_random(350);
    idle_request();
    write_centre(REG_CENTER_X, 32'd0);
    write_centre(REG_CENTER_Y, 32'd0);
    test_random(80);
    idle_request();

    wait (expected_ground.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_ground.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
